// ===== rtl/core/hsls_pkg.sv =====
package hsls_pkg;

    // header name bytes to match at line start
    localparam int unsigned NAME_LEN = 15;
    localparam logic [3:0]  NAME_LAST = 4'(NAME_LEN - 1);

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [15:0] STATUS_MAX = 16'hFFFF;
    localparam logic [31:0] ACC_MAX    = 32'hFFFF_FFFF;

    // "Content-Length:" one byte per index
    function automatic logic [7:0] name_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = "C";
            4'd1:    b = "o";
            4'd2:    b = "n";
            4'd3:    b = "t";
            4'd4:    b = "e";
            4'd5:    b = "n";
            4'd6:    b = "t";
            4'd7:    b = "-";
            4'd8:    b = "L";
            4'd9:    b = "e";
            4'd10:   b = "n";
            4'd11:   b = "g";
            4'd12:   b = "t";
            4'd13:   b = "h";
            4'd14:   b = ":";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/http_status_length_scanner_top.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+-------------------------------------------
// input     | in        | i_in_valid / o_in_ready  | i_data_byte, i_last_byte
// result    | out       | o_out_valid / i_out_ready| o_status_code, o_content_length,
//           |           |                          | o_both_found, o_digit_overflow
//
// one header byte per cycle unless a result waits on a stalled output; a byte is held
// in the input register, is scanned by the phase logic and its result (if any) is loaded
// into the output register when the byte leaves the input register
// the rate is set by the combinational scan update (multiply-by-ten add and compare)
// i_rst_n is synchronous, active low; it clears the scanner state and both valids
// a stalled result holds only bytes that would produce another result; bytes that
// produce nothing keep flowing past a waiting result
module http_status_length_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_status_code,
    output logic [31:0] o_content_length,
    output logic        o_both_found,
    output logic        o_digit_overflow
);
    import hsls_pkg::*;

    // scan phases
    typedef enum logic [2:0] {
        PH_SEEK_SP,     // status line, look for first space
        PH_STATUS,      // status digits
        PH_SKIP,        // skip to newline
        PH_NAME,        // match header name at line start
        PH_SEEK_SP2,    // space after the name
        PH_LENGTH,      // length digits
        PH_DONE         // length taken, ignore bytes
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // scanner state
    t_phase      r_phase;
    logic [3:0]  r_match;
    logic [31:0] r_acc;
    logic [15:0] r_status;
    logic [31:0] r_length;
    logic        r_ovf;
    logic        r_rep;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_status;
    logic [31:0] r_out_length;
    logic        r_out_both;
    logic        r_out_ovf;

    // next scanner state
    t_phase      n_phase;
    logic [3:0]  n_match;
    logic [31:0] n_acc;
    logic [15:0] n_status;
    logic [31:0] n_length;
    logic        n_ovf;

    logic        w_is_digit;
    logic [35:0] w_mul;
    logic [31:0] w_acc_sat;
    logic        w_acc_ovf;
    logic        w_both;
    logic        w_res;
    logic        w_out_free;
    logic        w_fire;

    // accumulator times ten plus digit, as shifts and adds
    assign w_is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign w_mul      = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + {28'b0, r_in_byte - CH_ZERO};
    assign w_acc_ovf  = (w_mul[35:32] != 4'b0);
    assign w_acc_sat  = w_acc_ovf ? ACC_MAX : w_mul[31:0];

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_acc    = r_acc;
        n_status = r_status;
        n_length = r_length;
        n_ovf    = r_ovf;
        // carriage returns leave the scan untouched
        if (r_in_byte != CH_CR) begin
            case (r_phase)
                PH_SEEK_SP: begin
                    if (r_in_byte == CH_SP) begin
                        n_phase = PH_STATUS;
                        n_acc   = '0;
                    end
                end
                PH_STATUS: begin
                    if (w_is_digit) begin
                        n_acc = w_acc_sat;
                        n_ovf = r_ovf | w_acc_ovf;
                    end else begin
                        if (r_acc > {16'b0, STATUS_MAX}) begin
                            n_status = STATUS_MAX;
                            n_ovf    = 1'b1;
                        end else begin
                            n_status = r_acc[15:0];
                        end
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (r_in_byte == CH_LF) n_phase = PH_NAME;
                end
                PH_NAME: begin
                    if (r_match <= NAME_LAST && r_in_byte == name_byte(r_match)) begin
                        if (r_match == NAME_LAST) begin
                            n_match = '0;
                            n_phase = PH_SEEK_SP2;
                        end else begin
                            n_match = r_match + 4'd1;
                        end
                    end else begin
                        // a failing newline starts the next line at once
                        n_match = '0;
                        n_phase = (r_in_byte == CH_LF) ? PH_NAME : PH_SKIP;
                    end
                end
                PH_SEEK_SP2: begin
                    if (r_in_byte == CH_SP) begin
                        n_phase = PH_LENGTH;
                        n_acc   = '0;
                    end
                end
                PH_LENGTH: begin
                    if (w_is_digit) begin
                        n_acc = w_acc_sat;
                        n_ovf = r_ovf | w_acc_ovf;
                    end else begin
                        n_length = r_acc;
                        n_phase  = PH_DONE;
                    end
                end
                default: begin
                    // done, and the unused phase code, ignore bytes
                end
            endcase
        end
    end

    // a result goes out once per block, when both values are in or else at the end of the block
    assign w_both     = (n_status != 16'b0) && (n_length != 32'b0);
    assign w_res      = !r_rep && (w_both || r_in_last);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && (!w_res || w_out_free);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SEEK_SP;
            r_match     <= '0;
            r_acc       <= '0;
            r_status    <= '0;
            r_length    <= '0;
            r_ovf       <= 1'b0;
            r_rep       <= 1'b0;
        end else begin
            // input register
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_byte <= i_data_byte;
                r_in_last <= i_last_byte;
            end

            // output register drains on transfer, a new result reloads it
            if (w_fire && w_res) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_fire) begin
                if (w_res) begin
                    r_out_status <= n_status;
                    r_out_length <= n_length;
                    r_out_both   <= w_both;
                    r_out_ovf    <= n_ovf;
                end
                if (r_in_last) begin
                    // end of block re-arms the scanner
                    r_phase  <= PH_SEEK_SP;
                    r_match  <= '0;
                    r_acc    <= '0;
                    r_status <= '0;
                    r_length <= '0;
                    r_ovf    <= 1'b0;
                    r_rep    <= 1'b0;
                end else if (!r_rep) begin
                    r_phase  <= n_phase;
                    r_match  <= n_match;
                    r_acc    <= n_acc;
                    r_status <= n_status;
                    r_length <= n_length;
                    r_ovf    <= n_ovf;
                    r_rep    <= w_res;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status_code    = r_out_status;
    assign o_content_length = r_out_length;
    assign o_both_found     = r_out_both;
    assign o_digit_overflow = r_out_ovf;

    // once reported, both values must be in hand
    a_rep_has_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep |-> (r_status != 16'b0) && (r_length != 32'b0))
        else $error("reported without both values");

    // a both-found result carries nonzero values
    a_both_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_both) |-> (r_out_status != 16'b0) && (r_out_length != 32'b0))
        else $error("both_found with a zero value");

    // the last byte of a block re-arms the scanner
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> !r_rep && (r_phase == PH_SEEK_SP) && (r_status == 16'b0))
        else $error("scanner not re-armed after last byte");

endmodule
